// File: rtl/bscd_pkg.sv
`default_nettype none

package bscd_pkg;

    // Largest frame in bytes, STX and ETX and BCC included.
    localparam int unsigned MAX_FRAME = 256;
    localparam int unsigned PAYLOAD_CAP_INT = ((MAX_FRAME - 3) < 253) ? (MAX_FRAME - 3) : 253;
    localparam logic [7:0] PAYLOAD_CAP = 8'(PAYLOAD_CAP_INT);

    localparam logic [7:0] CODE_STX = 8'h02;
    localparam logic [7:0] CODE_ETX = 8'h03;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_BODY  = 2'd1,
        PH_CHECK = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] check;
        logic [7:0] count;
    } t_state;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload_byte;
        t_status    status;
        logic [7:0] length;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/bscd_step.sv
`default_nettype none

// Next frame state and the result word for one received byte.
module bscd_step (
    input  wire bscd_pkg::t_state  i_state,
    input  wire logic [7:0]        i_max_payload,
    input  wire logic [7:0]        i_rx_byte,
    output bscd_pkg::t_state       o_state,
    output logic                   o_res_valid,
    output bscd_pkg::t_result      o_res
);

    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '{kind: bscd_pkg::KIND_PAYLOAD, payload_byte: 8'd0,
                        status: bscd_pkg::ST_GOOD, length: 8'd0};

        unique case (i_state.phase)
            bscd_pkg::PH_BODY: begin
                if (i_rx_byte == bscd_pkg::CODE_ETX) begin
                    o_state.check = i_state.check ^ i_rx_byte;
                    o_state.phase = bscd_pkg::PH_CHECK;
                end else if (i_state.count >= i_max_payload) begin
                    // overrun: end the frame with a too-long verdict
                    o_res_valid    = 1'b1;
                    o_res.kind     = bscd_pkg::KIND_VERDICT;
                    o_res.status   = bscd_pkg::ST_TOO_LONG;
                    o_res.length   = i_state.count;
                    o_state.phase  = bscd_pkg::PH_HUNT;
                end else begin
                    o_state.check      = i_state.check ^ i_rx_byte;
                    o_state.count      = i_state.count + 8'd1;
                    o_res_valid        = 1'b1;
                    o_res.payload_byte = i_rx_byte;
                end
            end
            bscd_pkg::PH_CHECK: begin
                o_res_valid   = 1'b1;
                o_res.kind    = bscd_pkg::KIND_VERDICT;
                o_res.status  = (i_rx_byte == i_state.check) ? bscd_pkg::ST_GOOD
                                                             : bscd_pkg::ST_MISMATCH;
                o_res.length  = i_state.count;
                o_state.phase = bscd_pkg::PH_HUNT;
            end
            default: begin
                // hunt, and the unused phase code
                if (i_rx_byte == bscd_pkg::CODE_STX) begin
                    o_state.check = 8'd0;
                    o_state.count = 8'd0;
                    o_state.phase = bscd_pkg::PH_BODY;
                end else begin
                    o_state.phase = bscd_pkg::PH_HUNT;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/bsc_frame_deframer_core.sv
`default_nettype none

// Receive deframer for a BSC-style byte stream (STX payload ETX BCC).
// Input channel: one received byte per word on i_rx_byte, i_in_valid/o_in_ready.
// Output channel: one result word per payload byte (kind 0, the byte itself,
// passed on at once) and one verdict word per frame (kind 1, status good,
// BCC mismatch or too long, plus the payload length). Bytes outside a frame
// and STX and ETX give no word; the BCC or overrun byte gives the verdict.
// Drop the frame's bytes downstream when the verdict is not good.
// Config channel: i_cfg_valid/o_cfg_ready writes max_payload from i_cfg_data,
// clamped to 1..PAYLOAD_CAP. Write it only while the block is idle.
// Results are registered: each goes to the output register, or to the skid
// register while the output holds. Throughput: one byte per cycle while
// o_in_ready is high, set by the single registered pass through the step logic.
// Stall: a two-entry output stage (output register plus skid register) lets
// the block take a byte while a result waits; o_in_ready drops only while the
// skid register is full.
// Reset: hunt for STX, BCC and count cleared, max_payload = PAYLOAD_CAP, both
// output entries empty.
module bsc_frame_deframer_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_result_kind,
    output logic [7:0]      o_payload_byte,
    output logic [1:0]      o_frame_status,
    output logic [7:0]      o_frame_length,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    // frame state
    bscd_pkg::t_state  r_state;
    bscd_pkg::t_state  n_state;
    logic [7:0]        r_max_payload;
    logic [7:0]        n_max_payload;

    // output register and skid register
    logic              r_out_valid;
    bscd_pkg::t_result r_out;
    logic              r_skid_valid;
    bscd_pkg::t_result r_skid;

    logic              step_res_valid;
    bscd_pkg::t_result step_res;
    logic              in_fire;
    logic              out_fire;

    assign o_in_ready  = !r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = r_out_valid && i_out_ready;

    bscd_step u_step (
        .i_state       (r_state),
        .i_max_payload (r_max_payload),
        .i_rx_byte     (i_rx_byte),
        .o_state       (n_state),
        .o_res_valid   (step_res_valid),
        .o_res         (step_res)
    );

    // clamp the written limit into 1..PAYLOAD_CAP
    always_comb begin
        if (i_cfg_data == 8'd0) begin
            n_max_payload = 8'd1;
        end else if (i_cfg_data > bscd_pkg::PAYLOAD_CAP) begin
            n_max_payload = bscd_pkg::PAYLOAD_CAP;
        end else begin
            n_max_payload = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase <= bscd_pkg::PH_HUNT;
            r_state.check <= 8'd0;
            r_state.count <= 8'd0;
            r_max_payload <= bscd_pkg::PAYLOAD_CAP;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            if (i_cfg_valid) begin
                r_max_payload <= n_max_payload;
            end
        end
    end

    // Output stage control: refill the output register when it is empty or
    // taken; park a new result in the skid register when the output holds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_fire || !r_out_valid) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_fire && step_res_valid;
                end
            end else if (in_fire && step_res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Payload side: no reset needed.
    always_ff @(posedge i_clk) begin
        if (out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else begin
                r_out <= step_res;
            end
        end else if (in_fire && step_res_valid) begin
            r_skid <= step_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_out.kind;
    assign o_payload_byte = r_out.payload_byte;
    assign o_frame_status = r_out.status;
    assign o_frame_length = r_out.length;

    // The skid entry only fills behind a held output word.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register valid while output register empty");

    // An accepted STX while hunting opens a fresh frame.
    a_stx_opens_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_state.phase == bscd_pkg::PH_HUNT
         && i_rx_byte == bscd_pkg::CODE_STX)
        |=> (r_state.phase == bscd_pkg::PH_BODY && r_state.check == 8'd0
             && r_state.count == 8'd0))
        else $error("STX did not open a frame");

    // The payload limit stays within its clamped range.
    a_limit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_max_payload != 8'd0) && (r_max_payload <= bscd_pkg::PAYLOAD_CAP))
        else $error("max_payload out of range");

endmodule

`default_nettype wire
